>>> rtl/cnf_tok_pkg.sv
`default_nettype none

package cnf_tok_pkg;

    // Position counter width (line and column), 8 to 64
    localparam int POS_BITS = 32;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // Lexer modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_IDENT   = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;
    localparam logic [1:0] MODE_NUMBER  = 2'd3;

    // Byte classes
    typedef enum logic [2:0] {
        CL_INVALID = 3'd0,
        CL_BLANK   = 3'd1,
        CL_LETTER  = 3'd2,
        CL_NEWLINE = 3'd3,
        CL_DIGIT   = 3'd4,
        CL_MINUS   = 3'd5
    } char_class_t;

    // Token kinds
    localparam logic [2:0] TK_LIT = 3'd0;
    localparam logic [2:0] TK_P   = 3'd1;
    localparam logic [2:0] TK_E   = 3'd2;
    localparam logic [2:0] TK_A   = 3'd3;
    localparam logic [2:0] TK_CNF = 3'd4;
    localparam logic [2:0] TK_NL  = 3'd5;
    localparam logic [2:0] TK_END = 3'd6;
    localparam logic [2:0] TK_ERR = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ERR_BAD_IDENT = 3'd2;
    localparam logic [2:0] ERR_BAD_NUM   = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;

    // Input word function
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [31:0] literal_value;
        logic [2:0]         error_code;
        logic [31:0]        line_number;
        logic [31:0]        column_number;
        logic               last;
    } out_word_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cl;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            cl = CL_BLANK;
        else if (c >= CH_LA && c <= CH_LZ)
            cl = CL_LETTER;
        else if (c == CH_LF)
            cl = CL_NEWLINE;
        else if (c >= CH_0 && c <= CH_9)
            cl = CL_DIGIT;
        else if (c == CH_MINUS)
            cl = CL_MINUS;
        else
            cl = CL_INVALID;
        return cl;
    endfunction

    // Expected letter of "cnf" at a given identifier position
    function automatic logic [7:0] cnf_letter(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_C;
            2'd1:    ch = CH_N;
            default: ch = CH_F;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cnf_text_tokenizer.sv
`default_nettype none

// DIMACS / QDIMACS lexer, one text byte per word.
//
// Input channel (in_valid/in_ready/in_word): each word is either a text
// byte (func = 0) or an end-of-input marker (func = 1). Output channel
// (out_valid/out_ready/out_word): token words with kind, literal value,
// error code, line/column position and a last flag marking the final
// token caused by one input word.
//
// Each accepted word is lexed in the same cycle against the lexer state
// and its tokens (zero, one or two) are written into a 4-entry result
// queue; the first token can appear on out_word in the cycle after
// accept. Throughput is one input word per clock while in_ready is high.
// in_ready is high while the queue has room for two tokens, so a byte
// that closes a token on a newline (two tokens) always fits. With the
// receiver stalled, input stops once three or more token words are
// waiting, and the queue then holds at most four.
//
// Reset clears the lexer state, the position counters, the sticky error
// flag and the queue. After an error token no further word produces a
// token until reset, but input words are still accepted.
module cnf_text_tokenizer
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cnf_tok_pkg::in_word_t  in_word,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cnf_tok_pkg::out_word_t      out_word
);
    import cnf_tok_pkg::*;

    // Lexer state
    logic [1:0]          mode_reg,    mode_next;
    logic [7:0]          first_reg,   first_next;
    logic [2:0]          len_reg,     len_next;
    logic                match_reg,   match_next;
    logic [31:0]         accum_reg,   accum_next;
    logic                neg_reg,     neg_next;
    logic                bad_reg,     bad_next;
    logic [POS_BITS-1:0] line_reg,    line_next;
    logic [POS_BITS-1:0] col_reg,     col_next;
    logic                err_reg,     err_next;

    // Result queue
    out_word_t           rq_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]    rd_ptr_reg,  rd_ptr_next;
    logic [RQ_AW-1:0]    wr_ptr_reg,  wr_ptr_next;
    logic [RQ_AW:0]      cnt_reg,     cnt_next;

    logic                in_fire;
    logic                out_fire;
    char_class_t         cl;
    logic [7:0]          ch;
    logic [3:0]          digit;
    logic                closing;
    logic [1:0]          m;
    logic                failed;
    logic [2:0]          fail_code;
    logic [1:0]          n_tok;
    logic [2:0]          kind0, kind1;
    logic [31:0]         val0;
    out_word_t           res0, res1;
    logic [RQ_AW-1:0]    wr_ptr_p1;

    assign in_ready  = (cnt_reg <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign out_word  = rq_reg[rd_ptr_reg];

    assign ch    = in_word.text_byte;
    assign cl    = classify(ch);
    assign digit = 4'(ch - CH_0);
    assign closing = (cl == CL_BLANK) || (cl == CL_NEWLINE);

    // Lexing of one word
    always_comb
    begin
        mode_next  = mode_reg;
        first_next = first_reg;
        len_next   = len_reg;
        match_next = match_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        bad_next   = bad_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        err_next   = err_reg;
        m          = mode_reg;
        failed     = 1'b0;
        fail_code  = ERR_NONE;
        n_tok      = 2'd0;
        kind0      = TK_LIT;
        kind1      = TK_LIT;
        val0       = '0;

        if (in_fire && !err_reg)
        begin
            if (in_word.func == FUNC_END)
            begin
                if (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER)
                begin
                    failed    = 1'b1;
                    fail_code = ERR_EARLY_END;
                end
                else
                begin
                    kind0 = TK_END;
                    n_tok = 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (cl == CL_NEWLINE)
                begin
                    line_next = line_reg + 1'b1;
                    col_next  = '0;
                end

                if (mode_reg != MODE_COMMENT && cl == CL_INVALID)
                begin
                    failed    = 1'b1;
                    fail_code = ERR_BAD_CHAR;
                end
                else
                begin
                    // Close an open identifier
                    if (m == MODE_IDENT && closing)
                    begin
                        m = MODE_IDLE;
                        priority if (len_reg == 3'd1 && first_reg == CH_P)
                        begin
                            kind0 = TK_P;
                            n_tok = 2'd1;
                        end
                        else if (len_reg == 3'd1 && first_reg == CH_E)
                        begin
                            kind0 = TK_E;
                            n_tok = 2'd1;
                        end
                        else if (len_reg == 3'd1 && first_reg == CH_LA)
                        begin
                            kind0 = TK_A;
                            n_tok = 2'd1;
                        end
                        else if (len_reg == 3'd1 && first_reg == CH_C)
                        begin
                            m = MODE_COMMENT;
                        end
                        else if (len_reg == 3'd3 && match_reg)
                        begin
                            kind0 = TK_CNF;
                            n_tok = 2'd1;
                        end
                        else
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_BAD_IDENT;
                        end
                    end

                    // Close an open number
                    if (!failed && m == MODE_NUMBER && closing)
                    begin
                        m = MODE_IDLE;
                        if (bad_reg)
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_BAD_NUM;
                        end
                        else
                        begin
                            kind0 = TK_LIT;
                            val0  = neg_reg ? (32'd0 - accum_reg) : accum_reg;
                            n_tok = 2'd1;
                        end
                    end

                    if (!failed)
                    begin
                        unique case (m)
                            MODE_IDLE:
                            begin
                                if (cl == CL_LETTER)
                                begin
                                    m          = MODE_IDENT;
                                    first_next = ch;
                                    len_next   = 3'd1;
                                    match_next = (ch == CH_C);
                                end
                                else if (cl == CL_NEWLINE)
                                begin
                                    // second token when a token was just closed
                                    if (n_tok == 2'd0)
                                        kind0 = TK_NL;
                                    else
                                        kind1 = TK_NL;
                                    n_tok = n_tok + 2'd1;
                                end
                                else if (cl == CL_DIGIT || cl == CL_MINUS)
                                begin
                                    m          = MODE_NUMBER;
                                    bad_next   = 1'b0;
                                    neg_next   = (cl == CL_MINUS);
                                    accum_next = (cl == CL_DIGIT) ? 32'(digit) : 32'd0;
                                end
                            end
                            MODE_IDENT:
                            begin
                                if (len_reg < 3'd3 && ch != cnf_letter(len_reg[1:0]))
                                    match_next = 1'b0;
                                if (len_reg < 3'd4)
                                    len_next = len_reg + 3'd1;
                            end
                            MODE_COMMENT:
                            begin
                                if (cl == CL_NEWLINE)
                                    m = MODE_IDLE;
                            end
                            default:
                            begin
                                // accum * 10 as two shifts and an add
                                if (cl == CL_DIGIT)
                                    accum_next = (accum_reg << 3) + (accum_reg << 1)
                                                 + 32'(digit);
                                else
                                    bad_next = 1'b1;
                            end
                        endcase
                    end
                    mode_next = m;
                end
            end

            if (failed)
            begin
                err_next = 1'b1;
                kind0    = TK_ERR;
                val0     = '0;
                n_tok    = 2'd1;
            end
        end
    end

    // Assemble result words; position is taken after this byte
    always_comb
    begin
        res0.token_kind    = kind0;
        res0.literal_value = (kind0 == TK_LIT) ? val0 : 32'sd0;
        res0.error_code    = failed ? fail_code : ERR_NONE;
        res0.line_number   = 32'(line_next);
        res0.column_number = 32'(col_next);
        res0.last          = (n_tok == 2'd1);

        res1.token_kind    = kind1;
        res1.literal_value = 32'sd0;
        res1.error_code    = ERR_NONE;
        res1.line_number   = 32'(line_next);
        res1.column_number = 32'(col_next);
        res1.last          = 1'b1;
    end

    // Queue pointers and fill count
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + RQ_AW'(out_fire);
        wr_ptr_next = wr_ptr_reg + RQ_AW'(n_tok);
        cnt_next    = cnt_reg + (RQ_AW+1)'(n_tok) - (RQ_AW+1)'(out_fire);
    end

    always_ff @(posedge clk)
    begin
        if (n_tok != 2'd0)
            rq_reg[wr_ptr_reg] <= res0;
        if (n_tok == 2'd2)
            rq_reg[wr_ptr_p1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            first_reg  <= '0;
            len_reg    <= '0;
            match_reg  <= 1'b0;
            accum_reg  <= '0;
            neg_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            line_reg   <= '0;
            col_reg    <= '0;
            err_reg    <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
            match_reg  <= match_next;
            accum_reg  <= accum_next;
            neg_reg    <= neg_next;
            bad_reg    <= bad_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            err_reg    <= err_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/cnf_text_tokenizer_test.sv
`timescale 1ns / 1ps

module cnf_text_tokenizer_test;

    import cnf_tok_pkg::*;

    localparam int N_DIRECTED   = 30;
    localparam int RANDOM_WORDS = 1200;
    localparam int PHASE_WORDS  = 150;     // words per idling setting
    localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 400000;

    // One row of the directed table. When 'typed' is set, the kind, value
    // and error code of the last token the word causes are taken from the
    // row instead of from the lexer prediction.
    typedef struct {
        logic       func;
        logic [7:0] ch;
        bit         typed;
        logic [2:0] kind;
        logic [31:0] val;
        logic [2:0] err;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_word   = '0;
    logic      out_ready = 1'b1;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_word;

    cnf_text_tokenizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer prediction: a private copy of the lexer state, advanced once
    // per accepted word. Tokens it predicts wait in tokens_due until the
    // block hands them out.
    // ------------------------------------------------------------------
    logic [1:0]          scan_mode  = MODE_IDLE;
    logic [7:0]          word_head  = '0;     // first letter of an identifier
    logic [2:0]          word_len   = '0;     // saturates at 4
    logic                cnf_so_far = 1'b0;   // identifier still spells a prefix of "cnf"
    logic [31:0]         num_value  = '0;     // wraps mod 2^32
    logic                num_minus  = 1'b0;
    logic                num_broken = 1'b0;   // letter or minus seen inside the number
    logic [POS_BITS-1:0] lines_seen = '0;
    logic [POS_BITS-1:0] col_pos    = '0;
    logic                halted     = 1'b0;   // sticky after any error token

    out_word_t tokens_due[$];

    // Stimulus and scoreboard bookkeeping
    int       gap_pct        = 0;   // sender idle odds per word, percent
    int       stall_pct      = 0;   // receiver stall odds per cycle, percent
    bit       hold_off_req   = 1'b0;
    bit       hold_done      = 1'b0;
    int       words_sent     = 0;
    int       tokens_checked = 0;
    int       mismatches     = 0;
    int       cycle_count    = 0;
    int       kind_seen[8];
    logic [2:0] final_err    = ERR_NONE;

    stim_row_t directed_rows[N_DIRECTED];

    function automatic char_class_t class_of(input logic [7:0] c);
        char_class_t cl;
        cl = CL_INVALID;
        if (c == CH_MINUS)
            cl = CL_MINUS;
        if (c >= CH_0 && c <= CH_9)
            cl = CL_DIGIT;
        if (c >= CH_LA && c <= CH_LZ)
            cl = CL_LETTER;
        if (c == CH_LF)
            cl = CL_NEWLINE;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            cl = CL_BLANK;
        return cl;
    endfunction

    // Token stamped with the current line/column (low 32 bits).
    function automatic out_word_t make_token(input logic [2:0] kind,
                                             input logic [31:0] val,
                                             input logic [2:0] err);
        out_word_t t;
        t.token_kind    = kind;
        t.literal_value = val;
        t.error_code    = err;
        t.line_number   = 32'(lines_seen);
        t.column_number = 32'(col_pos);
        t.last          = 1'b0;
        return t;
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        halted = 1'b1;
        tokens_due.push_back(make_token(TK_ERR, '0, code));
    endfunction

    // Add one letter (or stray digit/minus) to the open identifier.
    function automatic void extend_ident(input logic [7:0] c);
        logic [7:0] want_ch;
        if (word_len < 3)
        begin
            case (word_len)
                3'd0:    want_ch = CH_C;
                3'd1:    want_ch = CH_N;
                default: want_ch = CH_F;
            endcase
            if (c != want_ch)
                cnf_so_far = 1'b0;
        end
        if (word_len < 4)
            word_len = word_len + 1'b1;
    endfunction

    // Advance the lexer by one word; returns how many tokens it queued.
    function automatic int lex_word(input in_word_t w);
        char_class_t cl;
        logic [7:0]  c;
        bit          closes;
        bit          failed;
        int          n;
        out_word_t   t;
        n = 0;
        failed = 1'b0;
        if (halted)
            return 0;
        c = w.text_byte;
        if (w.func == FUNC_END)
        begin
            if (scan_mode == MODE_IDENT || scan_mode == MODE_NUMBER)
                raise_error(ERR_EARLY_END);
            else
                tokens_due.push_back(make_token(TK_END, '0, ERR_NONE));
            n = 1;
        end
        else
        begin
            cl = class_of(c);
            closes = (cl == CL_BLANK || cl == CL_NEWLINE);
            // position moves before any token is stamped
            col_pos = col_pos + 1'b1;
            if (cl == CL_NEWLINE)
            begin
                lines_seen = lines_seen + 1'b1;
                col_pos = '0;
            end
            if (scan_mode != MODE_COMMENT && cl == CL_INVALID)
            begin
                raise_error(ERR_BAD_CHAR);
                n = 1;
                failed = 1'b1;
            end
            if (!failed && scan_mode == MODE_IDENT && closes)
            begin
                scan_mode = MODE_IDLE;
                if (word_len == 1 && word_head == CH_P)
                begin
                    tokens_due.push_back(make_token(TK_P, '0, ERR_NONE));
                    n++;
                end
                else if (word_len == 1 && word_head == CH_E)
                begin
                    tokens_due.push_back(make_token(TK_E, '0, ERR_NONE));
                    n++;
                end
                else if (word_len == 1 && word_head == CH_LA)
                begin
                    tokens_due.push_back(make_token(TK_A, '0, ERR_NONE));
                    n++;
                end
                else if (word_len == 1 && word_head == CH_C)
                    scan_mode = MODE_COMMENT;
                else if (word_len == 3 && cnf_so_far)
                begin
                    tokens_due.push_back(make_token(TK_CNF, '0, ERR_NONE));
                    n++;
                end
                else
                begin
                    raise_error(ERR_BAD_IDENT);
                    n = 1;
                    failed = 1'b1;
                end
            end
            if (!failed && scan_mode == MODE_NUMBER && closes)
            begin
                scan_mode = MODE_IDLE;
                if (num_broken)
                begin
                    raise_error(ERR_BAD_NUM);
                    n = 1;
                    failed = 1'b1;
                end
                else
                begin
                    tokens_due.push_back(make_token(TK_LIT,
                        num_minus ? 32'd0 - num_value : num_value, ERR_NONE));
                    n++;
                end
            end
            if (!failed)
            begin
                case (scan_mode)
                    MODE_IDLE:
                    begin
                        if (cl == CL_LETTER)
                        begin
                            scan_mode  = MODE_IDENT;
                            word_head  = c;
                            word_len   = '0;
                            cnf_so_far = 1'b1;
                            extend_ident(c);
                        end
                        else if (cl == CL_NEWLINE)
                        begin
                            tokens_due.push_back(make_token(TK_NL, '0, ERR_NONE));
                            n++;
                        end
                        else if (cl == CL_DIGIT || cl == CL_MINUS)
                        begin
                            scan_mode  = MODE_NUMBER;
                            num_broken = 1'b0;
                            num_minus  = (cl == CL_MINUS);
                            num_value  = (cl == CL_DIGIT) ? 32'(c - CH_0) : 32'd0;
                        end
                    end
                    MODE_IDENT:
                        extend_ident(c);
                    MODE_COMMENT:
                        if (cl == CL_NEWLINE)
                            scan_mode = MODE_IDLE;
                    default:
                        if (cl == CL_DIGIT)
                            num_value = num_value * 32'd10 + 32'(c - CH_0);
                        else
                            num_broken = 1'b1;
                endcase
            end
        end
        if (n > 0)
        begin
            t = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_word_t text_word(input logic [7:0] b);
        in_word_t w;
        w.func = FUNC_BYTE;
        w.text_byte = b;
        return w;
    endfunction

    // End marker; the byte field is ignored by the block, so fill it randomly
    function automatic in_word_t end_word();
        in_word_t w;
        w.func = FUNC_END;
        w.text_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Token delimiter: blank, or newline when allowed
    function automatic logic [7:0] pick_break(input bit allow_lf);
        logic [7:0] b;
        case ($urandom_range(0, allow_lf ? 3 : 2))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_CR;
            default: b = CH_LF;
        endcase
        return b;
    endfunction

    // Offer one word, possibly after an idle burst, and hold it until taken.
    // The lexer prediction runs at the accepting edge, so expected tokens
    // are queued in acceptance order.
    task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                             input logic [2:0] kind = TK_LIT,
                             input logic [31:0] val = '0,
                             input logic [2:0] err = ERR_NONE);
        int n;
        out_word_t t;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        n = lex_word(w);
        if (typed && n > 0)
        begin
            t = tokens_due.pop_back();
            t.token_kind    = kind;
            t.literal_value = val;
            t.error_code    = err;
            tokens_due.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off requested by
    // the stimulus so the result queue fills and in_ready drops.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker: every handed-out word is matched field by field with
    // the oldest predicted token.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_word_t want;
        string     bad;
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: token word with none expected: kind %0d lit %0d err %0d",
                             $realtime, out_word.token_kind, out_word.literal_value,
                             out_word.error_code);
            end
            else
            begin
                want = tokens_due.pop_front();
                bad = "";
                if (out_word.token_kind !== want.token_kind)
                    bad = {bad, " kind"};
                if (out_word.literal_value !== want.literal_value)
                    bad = {bad, " literal"};
                if (out_word.error_code !== want.error_code)
                    bad = {bad, " error"};
                if (out_word.line_number !== want.line_number)
                    bad = {bad, " line"};
                if (out_word.column_number !== want.column_number)
                    bad = {bad, " column"};
                if (out_word.last !== want.last)
                    bad = {bad, " last"};
                if (bad != "")
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: token word mismatch in%s", $realtime, bad);
                        $display("  expected kind %0d lit %0d err %0d line %0d col %0d last %0d",
                                 want.token_kind, want.literal_value, want.error_code,
                                 want.line_number, want.column_number, want.last);
                        $display("  actual   kind %0d lit %0d err %0d line %0d col %0d last %0d",
                                 out_word.token_kind, out_word.literal_value,
                                 out_word.error_code, out_word.line_number,
                                 out_word.column_number, out_word.last);
                    end
                end
                else
                begin
                    tokens_checked++;
                    kind_seen[want.token_kind]++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d tokens still due",
                 cycle_count, tokens_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int         i;
        int         k;
        int         ndig;
        int         seg;
        int         next_phase;
        bit         neg;
        logic [7:0] b;
        logic [7:0] brk;
        in_word_t   w;
        in_word_t   tail_q[$];

        // Directed table: each keyword with a different delimiter, cnf
        // closed by a newline (two tokens), a lone minus, the most
        // negative literal, a comment carrying invalid bytes, and an end
        // marker. Typed rows are readable straight from the text.
        directed_rows = '{
            '{FUNC_BYTE, CH_P,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_SPACE, 1'b1, TK_P,   32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_E,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_TAB,   1'b1, TK_E,   32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_LA,    1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_CR,    1'b1, TK_A,   32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_C,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_N,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_F,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_LF,    1'b1, TK_NL,  32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_MINUS, 1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_SPACE, 1'b1, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_MINUS, 1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "2",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "1",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "4",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "7",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "4",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "8",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "3",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "6",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "4",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, "8",      1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_SPACE, 1'b1, TK_LIT, 32'h8000_0000, ERR_NONE},
            '{FUNC_BYTE, CH_C,     1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_SPACE, 1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, 8'hFF,    1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, 8'h23,    1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_BYTE, CH_LF,    1'b0, TK_LIT, 32'd0,         ERR_NONE},
            '{FUNC_END,  8'h00,    1'b1, TK_END, 32'd0,         ERR_NONE}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with moderate idling on both sides
        gap_pct   = 25;
        stall_pct = 25;
        for (i = 0; i < N_DIRECTED; i++)
        begin
            w.func      = directed_rows[i].func;
            w.text_byte = directed_rows[i].ch;
            send_word(w, directed_rows[i].typed, directed_rows[i].kind,
                      directed_rows[i].val, directed_rows[i].err);
        end

        // Random part. It opens with the long receiver hold-off while the
        // sender streams without gaps, then switches idling settings every
        // 150 words, and ends with a stretch of no idling at all.
        // Text is kept well formed so the lexer never trips its sticky
        // error before the very end; invalid bytes live inside comments.
        gap_pct      = 0;
        stall_pct    = 0;
        hold_off_req = 1'b1;
        next_phase   = words_sent + PHASE_WORDS;
        while (words_sent < N_DIRECTED + RANDOM_WORDS)
        begin
            if (words_sent >= next_phase)
            begin
                next_phase = words_sent + PHASE_WORDS;
                if (words_sent >= N_DIRECTED + RANDOM_WORDS - PHASE_WORDS)
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                else
                begin
                    gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                end
            end

            seg = $urandom_range(0, 99);
            if (seg < 35)
            begin
                // number: mostly short, sometimes long enough to wrap
                neg  = ($urandom_range(0, 3) == 0);
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                   : $urandom_range(1, 3);
                if (neg && $urandom_range(0, 5) == 0)
                    ndig = 0;   // lone minus
                if (neg)
                    send_word(text_word(CH_MINUS));
                for (k = 0; k < ndig; k++)
                    send_word(text_word(CH_0 + 8'($urandom_range(0, 9))));
                send_word(text_word(pick_break(1'b1)));
            end
            else if (seg < 60)
            begin
                case ($urandom_range(0, 3))
                    0: send_word(text_word(CH_P));
                    1: send_word(text_word(CH_E));
                    2: send_word(text_word(CH_LA));
                    default:
                    begin
                        send_word(text_word(CH_C));
                        send_word(text_word(CH_N));
                        send_word(text_word(CH_F));
                    end
                endcase
                send_word(text_word(pick_break(1'b1)));
            end
            else if (seg < 72)
            begin
                // comment: any byte but newline is swallowed; an end marker
                // inside an unterminated comment still gives END
                send_word(text_word(CH_C));
                brk = pick_break(1'b1);
                send_word(text_word(brk));
                if (brk != CH_LF)
                begin
                    ndig = $urandom_range(0, 8);
                    for (k = 0; k < ndig; k++)
                    begin
                        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                        send_word(text_word(b));
                    end
                    if ($urandom_range(0, 4) == 0)
                        send_word(end_word());
                    send_word(text_word(CH_LF));
                end
            end
            else if (seg < 82)
            begin
                repeat ($urandom_range(1, 3)) send_word(text_word(pick_break(1'b0)));
            end
            else if (seg < 92)
                send_word(text_word(CH_LF));
            else
                send_word(end_word());
        end

        // Closing error: only one error kind fits in a run, since errors
        // stick until reset. The seed picks which; the lexer is idle here.
        gap_pct   = 0;
        stall_pct = 0;
        final_err = 3'($urandom_range(1, 4));
        case (final_err)
            ERR_BAD_CHAR:
            begin
                do b = 8'($urandom_range(0, 255)); while (class_of(b) != CL_INVALID);
                tail_q.push_back(text_word(b));
            end
            ERR_BAD_IDENT:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // too long to be cnf
                    tail_q.push_back(text_word(CH_C));
                    tail_q.push_back(text_word(CH_N));
                    tail_q.push_back(text_word(CH_F));
                    tail_q.push_back(text_word("x"));
                    tail_q.push_back(text_word(CH_SPACE));
                end
                else
                begin
                    // digit kept inside an identifier
                    tail_q.push_back(text_word(CH_P));
                    tail_q.push_back(text_word("7"));
                    tail_q.push_back(text_word(CH_LF));
                end
            end
            ERR_BAD_NUM:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    tail_q.push_back(text_word("1"));
                    tail_q.push_back(text_word(CH_LA));
                    tail_q.push_back(text_word(CH_SPACE));
                end
                else
                begin
                    tail_q.push_back(text_word(CH_MINUS));
                    tail_q.push_back(text_word(CH_MINUS));
                    tail_q.push_back(text_word(CH_LF));
                end
            end
            default:
            begin
                // end marker with a token still open
                if ($urandom_range(0, 1) == 0)
                begin
                    tail_q.push_back(text_word("4"));
                    tail_q.push_back(text_word("2"));
                end
                else
                    tail_q.push_back(text_word(CH_P));
                tail_q.push_back(end_word());
            end
        endcase
        for (i = 0; i < tail_q.size(); i++)
            send_word(tail_q[i], i == tail_q.size() - 1, TK_ERR, '0, final_err);

        // After the error nothing may come out, bytes or end markers alike
        repeat (24)
        begin
            if ($urandom_range(0, 5) == 0)
                send_word(end_word());
            else
                send_word(text_word(8'($urandom_range(0, 255))));
        end
        in_valid <= 1'b0;

        // Drain, then leave room for any stray token to show up
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d input words, %0d tokens checked: lit %0d p %0d e %0d a %0d",
                 words_sent, tokens_checked, kind_seen[TK_LIT], kind_seen[TK_P],
                 kind_seen[TK_E], kind_seen[TK_A]);
        $display("cnf %0d newline %0d end %0d, closing error code %0d, %0d mismatches",
                 kind_seen[TK_CNF], kind_seen[TK_NL], kind_seen[TK_END], final_err,
                 mismatches);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> cnf_text_tokenizer.f
rtl/cnf_tok_pkg.sv
rtl/cnf_text_tokenizer.sv
tb/sv/cnf_text_tokenizer_test.sv
